/* hdl/page_dirty_stability_tracker_core_macros.svh */
// Assertion macros for the page dirty-stability tracker.
`ifndef PAGE_DIRTY_STABILITY_TRACKER_CORE_MACROS_SVH
`define PAGE_DIRTY_STABILITY_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define PDST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdst assertion failed");

// next-cycle implication
`define PDST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdst assertion failed");

`endif

/* hdl/pdst_pkg.sv */
// Types, constants and helpers of the page dirty-stability tracker.
package pdst_pkg;

  localparam int PAGE_AW   = 16;
  localparam int PAGES     = 1 << PAGE_AW;
  localparam int HIST_AW   = 10;
  localparam int HIST_BINS = 1 << HIST_AW;
  localparam int SWEEP_W   = 16;

  localparam logic [1:0] OP_OBSERVE  = 2'd0;
  localparam logic [1:0] OP_FINALIZE = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  localparam logic [1:0] KIND_INC     = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_HIST    = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [PAGE_AW-1:0] page_index;
    logic [SWEEP_W-1:0] sweep_number;
    logic               page_present;
    logic               soft_dirty;
    logic [HIST_AW-1:0] hist_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [PAGE_AW-1:0] out_page;
    logic [15:0]        present_total;
    logic [15:0]        dirty_total;
    logic [15:0]        longest_stable;
    logic [15:0]        current_stable;
    logic [15:0]        incarnation_number;
    logic [SWEEP_W-1:0] sweep_first;
    logic [SWEEP_W-1:0] sweep_last;
    logic [31:0]        hist_count;
    logic [31:0]        hist_final_count;
    logic               is_last;
  } out_word_t;

  typedef struct packed {
    logic [15:0]        present_total;
    logic [15:0]        dirty_total;
    logic [15:0]        clean_run;
    logic [15:0]        longest_run;
    logic               inc_open;
    logic [15:0]        inc_number;
    logic [SWEEP_W-1:0] inc_first;
    logic [SWEEP_W-1:0] inc_last;
    logic [15:0]        inc_present;
    logic [15:0]        inc_dirty;
  } page_ent_t;

  typedef struct packed {
    logic               wr_en;
    logic               log_en;
    logic               log_fin;
    logic [HIST_AW-1:0] log_bin;
    logic [1:0]         nres;
  } upd_ctl_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

/* hdl/page_dirty_stability_tracker_core.sv */
// Top level of the page dirty-stability tracker: page table, histogram, control.
//
//  channel | ports                        | word
//  input   | in_valid  in_stall  in_word  | operation, page, sweep, bits, bin
//  output  | out_valid out_stall out_word | record, summary or histogram bin
//
// One item at a time: the page table is read, then the histogram bin when a
// clean run is logged into it, then each result is sent in turn; both memories
// have registered reads. After reset a clearing pass over every page address
// zeroes both memories; no item is taken meanwhile. A stalled output
// holds the block in its result state; the next item is taken once the last
// result sits in the output register.
module page_dirty_stability_tracker_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pdst_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output pdst_pkg::out_word_t out_word
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_PRD   = 6'b000100,
    ST_HRD   = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_EMIT2 = 6'b100000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [pdst_pkg::PAGE_AW-1:0] clr_cnt_r;
  pdst_pkg::in_word_t           item_r;
  pdst_pkg::out_word_t          res0_r, res1_r, res0_c, res1_c;
  pdst_pkg::out_word_t          hist_res;
  logic                         two_r;
  logic                         has_res_r;
  logic                         fin_r;
  logic [pdst_pkg::HIST_AW-1:0] bin_r;
  logic                         out_valid_r;
  pdst_pkg::out_word_t          out_word_r;

  pdst_pkg::page_ent_t          page_mem [pdst_pkg::PAGES];
  pdst_pkg::page_ent_t          page_q_r, ent_nxt;
  logic [63:0]                  hist_mem [pdst_pkg::HIST_BINS];
  logic [63:0]                  hist_q_r;
  pdst_pkg::upd_ctl_t           ctl;

  logic                         accept, out_free;
  logic [pdst_pkg::HIST_AW-1:0] hist_raddr;
  logic                         page_we, hist_we;
  logic [pdst_pkg::PAGE_AW-1:0] page_waddr;
  pdst_pkg::page_ent_t          page_wdata;
  logic [pdst_pkg::HIST_AW-1:0] hist_waddr;
  logic [63:0]                  hist_wdata;

  pdst_update u_upd (
    .item    (item_r),
    .ent     (page_q_r),
    .ent_nxt (ent_nxt),
    .res0    (res0_c),
    .res1    (res1_c),
    .ctl     (ctl)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign hist_raddr = (state_r == ST_PRD) ? ctl.log_bin : in_word.hist_index;

  always_comb begin
    hist_res                  = '0;
    hist_res.result_kind      = pdst_pkg::KIND_HIST;
    hist_res.hist_count       = hist_q_r[63:32];
    hist_res.hist_final_count = hist_q_r[31:0];
    hist_res.is_last          = 1'b1;
  end

  always_comb begin
    page_we    = 1'b0;
    page_waddr = item_r.page_index;
    page_wdata = ent_nxt;
    hist_we    = 1'b0;
    hist_waddr = bin_r;
    hist_wdata = {pdst_pkg::sat_inc32(hist_q_r[63:32]),
                  fin_r ? pdst_pkg::sat_inc32(hist_q_r[31:0]) : hist_q_r[31:0]};
    if (state_r == ST_CLEAR) begin
      page_we    = 1'b1;
      page_waddr = clr_cnt_r;
      page_wdata = '0;
      hist_we    = (clr_cnt_r < pdst_pkg::PAGE_AW'(pdst_pkg::HIST_BINS));
      hist_waddr = pdst_pkg::HIST_AW'(clr_cnt_r);
      hist_wdata = '0;
    end else if (state_r == ST_PRD) begin
      page_we = ctl.wr_en;
    end else if (state_r == ST_HRD) begin
      hist_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (page_we) page_mem[page_waddr] <= page_wdata;
    if (accept) page_q_r <= page_mem[in_word.page_index];
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    if (accept || state_r == ST_PRD) hist_q_r <= hist_mem[hist_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_PRD;
      ST_PRD: begin
        if (item_r.operation == pdst_pkg::OP_READ) state_nxt = ST_EMIT;
        else if (ctl.log_en) state_nxt = ST_HRD;
        else if (ctl.nres != 2'd0) state_nxt = ST_EMIT;
        else state_nxt = ST_IDLE;
      end
      ST_HRD:   state_nxt = has_res_r ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (out_free) state_nxt = two_r ? ST_EMIT2 : ST_IDLE;
      ST_EMIT2: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + pdst_pkg::PAGE_AW'(1);
      if ((state_r == ST_EMIT || state_r == ST_EMIT2) && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_word;
    if (state_r == ST_PRD) begin
      bin_r <= ctl.log_bin;
      fin_r <= ctl.log_fin;
      if (item_r.operation == pdst_pkg::OP_READ) begin
        res0_r    <= hist_res;
        two_r     <= 1'b0;
        has_res_r <= 1'b1;
      end else begin
        // observes without a result may still pass HRD for the log
        res0_r    <= res0_c;
        two_r     <= (ctl.nres == 2'd2);
        has_res_r <= (ctl.nres != 2'd0);
      end
      res1_r <= res1_c;
    end
    if (state_r == ST_EMIT && out_free) out_word_r <= res0_r;
    if (state_r == ST_EMIT2 && out_free) out_word_r <= res1_r;
  end

  `include "page_dirty_stability_tracker_core_macros.svh"

  `PDST_ASSERT_NXT(a_accept_reads, accept, state_r == ST_PRD)
  `PDST_ASSERT_IMP(a_clear_quiet, state_r == ST_CLEAR, !out_valid_r)
  `PDST_ASSERT_IMP(a_hrd_after_prd, state_r == ST_HRD, $past(state_r) == ST_PRD)

endmodule

/* hdl/pdst_update.sv */
// Per-page read-modify-write logic: new table entry, results and histogram log.
module pdst_update (
  input  pdst_pkg::in_word_t  item,
  input  pdst_pkg::page_ent_t ent,
  output pdst_pkg::page_ent_t ent_nxt,
  output pdst_pkg::out_word_t res0,
  output pdst_pkg::out_word_t res1,
  output pdst_pkg::upd_ctl_t  ctl
);

  logic [15:0]             run_len;
  logic                    close_inc;
  pdst_pkg::out_word_t     rec;

  always_comb begin
    rec                    = '0;
    rec.result_kind        = pdst_pkg::KIND_INC;
    rec.out_page           = item.page_index;
    rec.present_total      = ent.inc_present;
    rec.dirty_total        = ent.inc_dirty;
    rec.incarnation_number = (ent.inc_number != 16'd0) ? ent.inc_number - 16'd1 : 16'd0;
    rec.sweep_first        = ent.inc_first;
    rec.sweep_last         = ent.inc_last;
    rec.is_last            = 1'b1;
  end

  always_comb begin
    ent_nxt   = ent;
    res0      = '0;
    res1      = '0;
    ctl       = '0;
    run_len   = ent.clean_run;
    close_inc = ent.inc_open &&
                ({1'b0, item.sweep_number} > ({1'b0, ent.inc_last} + 17'd1));
    // bins above the top one fold into it
    ctl.log_bin = (run_len >= 16'(pdst_pkg::HIST_BINS)) ?
                  pdst_pkg::HIST_AW'(pdst_pkg::HIST_BINS - 1) :
                  pdst_pkg::HIST_AW'(run_len);
    case (item.operation)
      pdst_pkg::OP_OBSERVE: begin
        if (item.page_present) begin
          ctl.wr_en = 1'b1;
          ent_nxt.present_total = pdst_pkg::sat_inc16(ent.present_total);
          if (item.soft_dirty) begin
            ent_nxt.dirty_total = pdst_pkg::sat_inc16(ent.dirty_total);
            if (ent.clean_run > ent.longest_run) ent_nxt.longest_run = ent.clean_run;
            ctl.log_en = (run_len != 16'd0);
            ent_nxt.clean_run = 16'd0;
          end else begin
            ent_nxt.clean_run = pdst_pkg::sat_inc16(ent.clean_run);
          end
          if (close_inc) begin
            res0     = rec;
            ctl.nres = 2'd1;
          end
          if (close_inc || !ent.inc_open) begin
            ent_nxt.inc_open    = 1'b1;
            ent_nxt.inc_number  = pdst_pkg::sat_inc16(ent.inc_number);
            ent_nxt.inc_first   = item.sweep_number;
            ent_nxt.inc_present = 16'd1;
            ent_nxt.inc_dirty   = {15'd0, item.soft_dirty};
          end else begin
            ent_nxt.inc_present = pdst_pkg::sat_inc16(ent.inc_present);
            if (item.soft_dirty) ent_nxt.inc_dirty = pdst_pkg::sat_inc16(ent.inc_dirty);
          end
          ent_nxt.inc_last = item.sweep_number;
        end
      end
      pdst_pkg::OP_FINALIZE: begin
        ctl.wr_en = 1'b1;
        if (run_len != 16'd0) begin
          ctl.log_en  = 1'b1;
          ctl.log_fin = 1'b1;
          if (ent.clean_run > ent.longest_run) ent_nxt.longest_run = ent.clean_run;
        end
        res0.result_kind    = pdst_pkg::KIND_SUMMARY;
        res0.out_page       = item.page_index;
        res0.present_total  = ent.present_total;
        res0.dirty_total    = ent.dirty_total;
        res0.longest_stable = ent_nxt.longest_run;
        res0.current_stable = ent.clean_run;
        res0.is_last        = !ent.inc_open;
        res1                = rec;
        ent_nxt.inc_open    = 1'b0;
        ctl.nres            = ent.inc_open ? 2'd2 : 2'd1;
      end
      default: ;
    endcase
  end

endmodule
